@@ src/mhema_pkg.sv @@
// Shared types and constants for the multichannel hysteresis moving-average filter.
// Holds the input and result word layouts, field widths and register indexes.
// No dependencies.
`default_nettype none

package mhema_pkg;

  localparam int KNOB_COUNT = 6;
  localparam int AVG_DEPTH  = KNOB_COUNT + 1;
  localparam int KNOB_AW    = $clog2(KNOB_COUNT);
  localparam int AVG_AW     = $clog2(AVG_DEPTH);

  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 12;
  localparam int AVG_W      = 16;
  localparam int COEF_W     = 16;
  localparam int THR_W      = 12;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CH_W-1:0] CV_CHANNEL = CH_W'(KNOB_COUNT);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOB_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CV_COEF   = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 12'd8;
  localparam logic [COEF_W-1:0] KNOB_COEF_RESET = 16'd3277;
  localparam logic [COEF_W-1:0] CV_COEF_RESET   = 16'd9830;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [AVG_W-1:0] smoothed_value;
    logic             held;
  } out_word_t;

endpackage

`default_nettype wire

@@ src/multichannel_hysteresis_ema_filter_core.sv @@
// Words pass registers s1, s2 and the output register. Throughput: one word per
// cycle unless out_ready stalls, including back-to-back words on one channel;
// the average update (subtract, 17x17 multiply, add, clamp) closes in one stage.
// Reset: configuration returns to defaults and per-entry valid bits clear,
// so every channel's held sample and average read as zero until written.
// Depends on mhema_pkg.
`default_nettype none

module multichannel_hysteresis_ema_filter_core (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire  mhema_pkg::in_word_t               in_data,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output mhema_pkg::out_word_t                    out_data,
  input  wire                                     cfg_we,
  input  wire  [mhema_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [mhema_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [mhema_pkg::THR_W-1:0]  threshold;
  logic [mhema_pkg::COEF_W-1:0] knob_coef;
  logic [mhema_pkg::COEF_W-1:0] cv_coef;

  logic [mhema_pkg::SAMPLE_W-1:0] last_mem [mhema_pkg::KNOB_COUNT];
  logic [mhema_pkg::AVG_W-1:0]    avg_mem  [mhema_pkg::AVG_DEPTH];
  logic [mhema_pkg::KNOB_COUNT-1:0] last_vld;
  logic [mhema_pkg::AVG_DEPTH-1:0]  avg_vld;

  logic                           s1_valid;
  logic [mhema_pkg::CH_W-1:0]     s1_ch;
  logic [mhema_pkg::SAMPLE_W-1:0] s1_sample;
  logic [mhema_pkg::SAMPLE_W-1:0] s1_last;
  logic [mhema_pkg::AVG_W-1:0]    s1_avg;

  logic                           s2_valid;
  logic [mhema_pkg::CH_W-1:0]     s2_ch;
  logic [mhema_pkg::AVG_W-1:0]    s2_target;
  logic [mhema_pkg::COEF_W-1:0]   s2_coef;
  logic                           s2_held;
  logic [mhema_pkg::AVG_W-1:0]    s2_avg;

  logic out_load, fire2, s2_free, fire1, in_fire, in_ok, in_knob;
  logic [mhema_pkg::KNOB_AW-1:0] in_kaddr;
  logic [mhema_pkg::AVG_AW-1:0]  in_aaddr;

  logic                           s1_knob;
  logic [mhema_pkg::SAMPLE_W-1:0] s1_delta;
  logic                           s1_held;
  logic [mhema_pkg::SAMPLE_W-1:0] s1_raw;
  logic [mhema_pkg::AVG_W-1:0]    s1_target;
  logic [mhema_pkg::COEF_W-1:0]   s1_coef;

  logic signed [mhema_pkg::AVG_W:0]     s2_diff;
  logic signed [2*mhema_pkg::AVG_W+1:0] s2_prod;
  logic signed [mhema_pkg::AVG_W+1:0]   s2_step;
  logic signed [mhema_pkg::AVG_W+2:0]   s2_sum;
  logic [mhema_pkg::AVG_W-1:0]          s2_avg_next;

  // Handshake and stage enables
  always_comb begin
    out_load = !out_valid || out_ready;
    fire2    = s2_valid && out_load;
    s2_free  = !s2_valid || fire2;
    fire1    = s1_valid && s2_free;
    in_ready = !s1_valid || fire1;
    in_fire  = in_valid && in_ready;
    in_ok    = in_data.channel <= mhema_pkg::CV_CHANNEL;
    in_knob  = in_data.channel < mhema_pkg::CV_CHANNEL;
    in_kaddr = in_data.channel[mhema_pkg::KNOB_AW-1:0];
    in_aaddr = in_data.channel[mhema_pkg::AVG_AW-1:0];
  end

  // Hysteresis and target
  always_comb begin
    s1_knob  = s1_ch < mhema_pkg::CV_CHANNEL;
    s1_delta = (s1_sample >= s1_last) ? (s1_sample - s1_last) : (s1_last - s1_sample);
    s1_held  = s1_knob && (s1_delta < threshold);
    s1_raw   = s1_held ? s1_last : s1_sample;
    s1_target = {s1_raw, 4'b0000} + mhema_pkg::AVG_W'(s1_raw >> 8);
    s1_coef  = s1_knob ? knob_coef : cv_coef;
  end

  // Moving-average update
  always_comb begin
    s2_diff = $signed({1'b0, s2_target}) - $signed({1'b0, s2_avg});
    s2_prod = $signed({1'b0, s2_coef}) * s2_diff;
    s2_step = s2_prod[2*mhema_pkg::AVG_W+1:mhema_pkg::AVG_W];
    s2_sum  = $signed({3'b000, s2_avg}) + $signed({s2_step[mhema_pkg::AVG_W+1], s2_step});
    if (s2_sum[mhema_pkg::AVG_W+2]) begin
      s2_avg_next = '0;
    end else if (s2_sum[mhema_pkg::AVG_W+1:mhema_pkg::AVG_W] != 2'b00) begin
      s2_avg_next = '1;
    end else begin
      s2_avg_next = s2_sum[mhema_pkg::AVG_W-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= mhema_pkg::THRESHOLD_RESET;
      knob_coef <= mhema_pkg::KNOB_COEF_RESET;
      cv_coef   <= mhema_pkg::CV_COEF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mhema_pkg::CFG_THRESHOLD: threshold <= cfg_data[mhema_pkg::THR_W-1:0];
        mhema_pkg::CFG_KNOB_COEF: knob_coef <= cfg_data[mhema_pkg::COEF_W-1:0];
        mhema_pkg::CFG_CV_COEF:   cv_coef   <= cfg_data[mhema_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // State memories: write back
  always_ff @(posedge clk) begin
    if (fire1 && s1_knob) begin
      last_mem[s1_ch[mhema_pkg::KNOB_AW-1:0]] <= s1_raw;
    end
    if (fire2) begin
      avg_mem[s2_ch[mhema_pkg::AVG_AW-1:0]] <= s2_avg_next;
    end
  end

  // State memories: registered read with bypass of same-edge writes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch     <= in_data.channel;
      s1_sample <= in_data.sample;
      if (!in_knob) begin
        s1_last <= '0;
      end else if (fire1 && s1_knob && (s1_ch == in_data.channel)) begin
        s1_last <= s1_raw;
      end else if (last_vld[in_kaddr]) begin
        s1_last <= last_mem[in_kaddr];
      end else begin
        s1_last <= '0;
      end
      if (!in_ok) begin
        s1_avg <= '0;
      end else if (fire2 && (s2_ch == in_data.channel)) begin
        s1_avg <= s2_avg_next;
      end else if (avg_vld[in_aaddr]) begin
        s1_avg <= avg_mem[in_aaddr];
      end else begin
        s1_avg <= '0;
      end
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      last_vld <= '0;
      avg_vld  <= '0;
    end else begin
      if (fire1 && s1_knob) begin
        last_vld[s1_ch[mhema_pkg::KNOB_AW-1:0]] <= 1'b1;
      end
      if (fire2) begin
        avg_vld[s2_ch[mhema_pkg::AVG_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Stage valids; drop words for channels above the CV channel
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_fire && in_ok;
      end
      if (s2_free) begin
        s2_valid <= fire1;
      end
      if (out_load) begin
        out_valid <= fire2;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (fire1) begin
      s2_ch     <= s1_ch;
      s2_target <= s1_target;
      s2_coef   <= s1_coef;
      s2_held   <= s1_held;
      s2_avg    <= (fire2 && (s2_ch == s1_ch)) ? s2_avg_next : s1_avg;
    end
    if (fire2) begin
      out_data.channel_out    <= s2_ch;
      out_data.smoothed_value <= s2_avg_next;
      out_data.held           <= s2_held;
    end
  end

endmodule

`default_nettype wire

@@ tb/mhema_filter_checker.sv @@
// Watches the sample and result channels and the register port of the filter core,
// keeps its own copy of the hysteresis and moving-average state, and compares words.
// Depends on mhema_pkg.
`timescale 1ns / 100ps

module mhema_filter_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  input  wire                                in_ready,
  input  mhema_pkg::in_word_t                in_data,
  input  wire                                out_valid,
  input  wire                                out_ready,
  input  mhema_pkg::out_word_t               out_data,
  input  wire                                cfg_we,
  input  wire [mhema_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [mhema_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 words_outstanding,
  output int                                 mismatch_count
);

  logic [mhema_pkg::THR_W-1:0]    threshold;
  logic [mhema_pkg::COEF_W-1:0]   knob_coef;
  logic [mhema_pkg::COEF_W-1:0]   cv_coef;
  logic [mhema_pkg::SAMPLE_W-1:0] accepted_sample [mhema_pkg::KNOB_COUNT];
  logic [mhema_pkg::AVG_W-1:0]    channel_avg [mhema_pkg::AVG_DEPTH];
  mhema_pkg::out_word_t           awaited_words [$];

  function automatic logic [mhema_pkg::AVG_W-1:0] next_average(
      input logic [mhema_pkg::AVG_W-1:0]    avg,
      input logic [mhema_pkg::SAMPLE_W-1:0] raw,
      input logic [mhema_pkg::COEF_W-1:0]   coef);
    longint target;
    longint moved;
    target = 16 * longint'(raw) + longint'(raw >> 8);
    moved  = longint'(avg) + ((longint'(coef) * (target - longint'(avg))) >>> 16);
    if (moved < 0) moved = 0;
    if (moved > 65535) moved = 65535;
    return moved[mhema_pkg::AVG_W-1:0];
  endfunction

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic filter_sample(input mhema_pkg::in_word_t w);
    mhema_pkg::out_word_t           want;
    logic [mhema_pkg::SAMPLE_W-1:0] raw;
    logic [mhema_pkg::SAMPLE_W-1:0] delta;
    logic [mhema_pkg::COEF_W-1:0]   coef;
    if (w.channel > mhema_pkg::CV_CHANNEL) return;
    raw = w.sample;
    want.held = 1'b0;
    if (w.channel < mhema_pkg::CV_CHANNEL) begin
      delta = (raw >= accepted_sample[w.channel]) ? raw - accepted_sample[w.channel]
                                                  : accepted_sample[w.channel] - raw;
      if (delta < threshold) begin
        raw = accepted_sample[w.channel];
        want.held = 1'b1;
      end else begin
        accepted_sample[w.channel] = raw;
      end
      coef = knob_coef;
    end else begin
      coef = cv_coef;
    end
    channel_avg[w.channel] = next_average(channel_avg[w.channel], raw, coef);
    want.channel_out = w.channel;
    want.smoothed_value = channel_avg[w.channel];
    awaited_words.push_back(want);
  endtask

  task automatic check_word(input mhema_pkg::out_word_t got);
    mhema_pkg::out_word_t want;
    if (awaited_words.size() == 0) begin
      report($sformatf("result word ch %0d with nothing awaited", got.channel_out));
      return;
    end
    want = awaited_words.pop_front();
    if (got.channel_out !== want.channel_out)
      report($sformatf("channel_out %0d, want %0d", got.channel_out, want.channel_out));
    if (got.smoothed_value !== want.smoothed_value)
      report($sformatf("ch %0d smoothed_value %0d, want %0d", want.channel_out,
                       got.smoothed_value, want.smoothed_value));
    if (got.held !== want.held)
      report($sformatf("ch %0d held %0b, want %0b", want.channel_out, got.held, want.held));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold = mhema_pkg::THRESHOLD_RESET;
      knob_coef = mhema_pkg::KNOB_COEF_RESET;
      cv_coef   = mhema_pkg::CV_COEF_RESET;
      foreach (accepted_sample[i]) accepted_sample[i] = '0;
      foreach (channel_avg[i]) channel_avg[i] = '0;
      awaited_words.delete();
      mismatch_count = 0;
      words_outstanding <= 0;
    end else begin
      if (out_valid && out_ready) check_word(out_data);
      if (cfg_we) begin
        case (cfg_index)
          mhema_pkg::CFG_THRESHOLD: threshold = cfg_data[mhema_pkg::THR_W-1:0];
          mhema_pkg::CFG_KNOB_COEF: knob_coef = cfg_data[mhema_pkg::COEF_W-1:0];
          mhema_pkg::CFG_CV_COEF:   cv_coef = cfg_data[mhema_pkg::COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) filter_sample(in_data);
      words_outstanding <= awaited_words.size();
    end
  end

endmodule

@@ tb/tb_multichannel_hysteresis_ema_filter_core.sv @@
// Top of the filter core testbench: clock, reset, sample and register stimulus, verdict.
// Depends on mhema_pkg, multichannel_hysteresis_ema_filter_core and mhema_filter_checker.
`timescale 1ns / 100ps

module tb_multichannel_hysteresis_ema_filter_core;

  localparam logic [mhema_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [mhema_pkg::CH_W-1:0]      NO_CHANNEL = 3'd7;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  mhema_pkg::in_word_t              in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  mhema_pkg::out_word_t             out_data;
  logic                             cfg_we = 1'b0;
  logic [mhema_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mhema_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                               words_outstanding;
  int                               mismatch_count;
  int                               idle_pct = 0;
  int                               stall_pct = 0;
  int                               cur_threshold = mhema_pkg::THRESHOLD_RESET;
  int                               last_sent [mhema_pkg::AVG_DEPTH];

  always #6 clk = ~clk;

  multichannel_hysteresis_ema_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mhema_filter_checker filter_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .words_outstanding (words_outstanding),
    .mismatch_count    (mismatch_count)
  );

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #3600000;
    $display("FAIL");
    $finish;
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        idle_pct = 60;
        stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        idle_pct = 0;
        stall_pct = 60;
      end
      default: begin
        idle_pct = 11;
        stall_pct = 11;
      end
    endcase
  endtask

  task automatic push_word(input logic [mhema_pkg::CH_W-1:0] ch, input int value);
    mhema_pkg::in_word_t w;
    w.channel = ch;
    w.sample = value[mhema_pkg::SAMPLE_W-1:0];
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (ch != NO_CHANNEL) last_sent[ch] = value;
  endtask

  // drop valid, drain all awaited words, then cover words that make no result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input int thr, input int knob_c, input int cv_c,
                                input bit poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= mhema_pkg::CFG_THRESHOLD;
    cfg_data <= mhema_pkg::CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= mhema_pkg::CFG_KNOB_COEF;
    cfg_data <= mhema_pkg::CFG_DATA_W'(knob_c);
    @(posedge clk);
    cfg_index <= mhema_pkg::CFG_CV_COEF;
    cfg_data <= mhema_pkg::CFG_DATA_W'(cv_c);
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data <= mhema_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_threshold = thr;
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2, 3: return $urandom_range(1, 40);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int pick_coef();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(1, 4096);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic push_random_word(output bit counted);
    logic [mhema_pkg::CH_W-1:0] ch;
    int span;
    int value;
    if ($urandom_range(0, 99) < 4) ch = NO_CHANNEL;
    else ch = mhema_pkg::CH_W'($urandom_range(0, mhema_pkg::KNOB_COUNT));
    case ($urandom_range(0, 9))
      0: value = $urandom_range(0, 1) ? 4095 : 0;
      1, 2: value = $urandom_range(0, 4095);
      default: begin
        span = (cur_threshold > 300 ? 300 : cur_threshold) + 2;
        value = (ch == NO_CHANNEL) ? $urandom_range(0, 4095) : last_sent[ch];
        value = value + $urandom_range(0, 2 * span) - span;
        if (value < 0) value = 0;
        if (value > 4095) value = 4095;
      end
    endcase
    push_word(ch, value);
    counted = (ch != NO_CHANNEL);
  endtask

  initial begin
    int count;
    bit counted;
    foreach (last_sent[i]) last_sent[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_pace(PACE_FULL);

    push_word(3'd0, 0);
    push_word(3'd0, 4095);
    push_word(3'd0, 4090);
    push_word(3'd0, 4087);
    push_word(3'd0, 0);
    push_word(3'd5, 4095);
    push_word(3'd5, 12'hAAA);
    push_word(3'd5, 12'h555);
    push_word(mhema_pkg::CV_CHANNEL, 4095);
    push_word(mhema_pkg::CV_CHANNEL, 0);
    push_word(mhema_pkg::CV_CHANNEL, 4095);
    push_word(NO_CHANNEL, 1234);
    push_word(NO_CHANNEL, 4095);
    push_word(3'd3, 2048);
    settle();

    write_settings(0, 65535, 65535, 1'b1);
    push_word(3'd1, 100);
    push_word(3'd1, 100);
    push_word(mhema_pkg::CV_CHANNEL, 4095);
    push_word(mhema_pkg::CV_CHANNEL, 4095);
    push_word(3'd2, 4095);
    settle();

    write_settings(4095, 0, 0, 1'b0);
    push_word(3'd0, 4095);
    push_word(3'd0, 0);
    push_word(3'd4, 2000);
    push_word(mhema_pkg::CV_CHANNEL, 1);
    push_word(3'd5, 4095);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      write_settings(pick_threshold(), pick_coef(), pick_coef(), 1'($urandom_range(0, 1)));
      set_pace(pace_t'(phase % 4));
      count = 0;
      while (count < 118) begin
        push_random_word(counted);
        if (counted) count++;
      end
      settle();
    end

    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
